FILE: design/pretrigger_capture_buffer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pretrigger capture buffer
// Concurrent checks that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PRETRIGGER_CAPTURE_BUFFER_ASSERT_SVH
`define PRETRIGGER_CAPTURE_BUFFER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, held off during reset
`define PCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pretrigger_capture_buffer: same-cycle check failed");
// Next-cycle implication, held off during reset
`define PCB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pretrigger_capture_buffer: next-cycle check failed");
`else
`define PCB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PCB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/pcb_pkg.sv
// ----------------------------------------------------------------------------
// pcb_pkg
// Sizes, codes and shared types of the pretrigger capture buffer.
// ----------------------------------------------------------------------------
package pcb_pkg;

    // Storage sizes
    localparam int DEPTH        = 1024;
    localparam int CHANNELS     = 4;
    localparam int SAMPLE_WIDTH = 32;

    // Derived widths
    localparam int AW     = $clog2(DEPTH);        // ring pointer
    localparam int LEN_W  = AW + 1;               // length and fill count
    localparam int CH_W   = $clog2(CHANNELS);     // channel select
    localparam int MA_W   = CH_W + AW;            // sample memory address
    localparam int BIT_W  = $clog2(AW);           // pointer bit select
    localparam int DATA_W = 32;                   // read_data port width

    // Item function codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_REARM = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes
    localparam logic REG_LEN  = 1'b0;
    localparam logic REG_POST = 1'b1;

    // Rewrapped write pointer update from the pointer normalizer
    typedef struct packed {
        logic            we;
        logic [CH_W-1:0] ch;
        logic [AW-1:0]   ptr;
    } t_ptr_wr;

endpackage

FILE: design/pretrigger_capture_buffer.sv
// ----------------------------------------------------------------------------
// pretrigger_capture_buffer
// Per-channel waveform capture ring with a pre/post trigger split.
// ----------------------------------------------------------------------------
// Takes one item per cycle (sample write, rearm or read) unless a rewrap
// or a full result path holds it off, and returns one status result per
// item through stage 1 and the output register; a result waiting at the
// output stops new items only once stage 1 is full too. The rate is set by
// the single sample memory port pair: one write and one registered read per
// cycle. Writing record_length starts a rewrap of all write pointers that
// blocks items. Channel pointers and flags live in flip-flops and update in
// the transfer cycle, so back-to-back items on one channel see fresh state.
// ----------------------------------------------------------------------------
`include "pretrigger_capture_buffer_assert.svh"

module pretrigger_capture_buffer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_func,
    input  logic [1:0]                   i_channel,
    input  logic                         i_trigger,
    input  logic [31:0]                  i_sample,
    input  logic [9:0]                   i_read_index,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [31:0]                  o_read_data,
    output logic                         o_armed,
    output logic                         o_triggered,
    output logic                         o_done_res,
    output logic [9:0]                   o_trigger_index,
    output logic [10:0]                  o_fill_count,
    // configuration
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [10:0]                  i_cfg_data
);

    localparam int AW    = pcb_pkg::AW;
    localparam int LEN_W = pcb_pkg::LEN_W;
    localparam int CH_W  = pcb_pkg::CH_W;
    localparam int MA_W  = pcb_pkg::MA_W;
    localparam int CHN   = pcb_pkg::CHANNELS;
    localparam int SW    = pcb_pkg::SAMPLE_WIDTH;

    // Configuration
    logic [LEN_W-1:0]   r_len;
    logic [AW-1:0]      r_post;
    logic [LEN_W-1:0]   len;

    // Channel state
    logic [AW-1:0]      r_wp_raw  [CHN];
    logic [AW-1:0]      r_wp_mod  [CHN];
    logic [LEN_W-1:0]   r_held    [CHN];
    logic [AW-1:0]      r_tpos    [CHN];
    logic [CHN-1:0]     r_armed;
    logic [CHN-1:0]     r_trig;
    logic [CHN-1:0]     r_done;

    // Sample memory
    logic [SW-1:0]      mem [CHN * pcb_pkg::DEPTH];
    logic [SW-1:0]      r_mem_q;
    logic               mem_we;
    logic               mem_re;
    logic [MA_W-1:0]    mem_wa;
    logic [MA_W-1:0]    mem_ra;

    // Pointer normalizer
    logic               norm_start;
    logic               norm_busy;
    logic [CH_W-1:0]    norm_sel;
    pcb_pkg::t_ptr_wr   norm_wr;

    // Handshake and pipeline
    logic               in_acc;
    logic               s1_mv;
    logic               r_s1_valid;
    logic               r_s1_rd;
    logic               r_s1_armed;
    logic               r_s1_trig;
    logic               r_s1_done;
    logic [AW-1:0]      r_s1_tidx;
    logic [LEN_W-1:0]   r_s1_fill;
    logic               r_out_valid;
    logic [31:0]        r_out_data;
    logic               r_out_armed;
    logic               r_out_trig;
    logic               r_out_done;
    logic [AW-1:0]      r_out_tidx;
    logic [LEN_W-1:0]   r_out_fill;

    // Item datapath
    logic [CH_W-1:0]    ch;
    logic               ch_ok;
    logic [AW-1:0]      w;
    logic [LEN_W-1:0]   h;
    logic [AW-1:0]      n;
    logic [LEN_W-1:0]   len_m_n;
    logic [LEN_W-1:0]   wp_inc;
    logic [AW-1:0]      wp_new;
    logic [LEN_W-1:0]   h1;
    logic [LEN_W-1:0]   keep;
    logic               do_write;
    logic               rd_hit;
    logic [LEN_W-1:0]   rd_off;
    logic [LEN_W-1:0]   rd_sum;
    logic [LEN_W-1:0]   rd_phys;
    logic               upd;
    logic [AW-1:0]      n_wp;
    logic [LEN_W-1:0]   n_held;
    logic [AW-1:0]      n_tpos;
    logic               n_armed;
    logic               n_trig;
    logic               n_done;
    logic [LEN_W-1:0]   n_fill;

    // Clamp the programmed length to the ring size
    always_comb begin
        if (r_len < LEN_W'(2)) begin
            len = LEN_W'(2);
        end else if (r_len > LEN_W'(pcb_pkg::DEPTH)) begin
            len = LEN_W'(pcb_pkg::DEPTH);
        end else begin
            len = r_len;
        end
    end

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_W'(1024);
            r_post <= AW'(512);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcb_pkg::REG_LEN:  r_len  <= i_cfg_data;
                pcb_pkg::REG_POST: r_post <= i_cfg_data[AW-1:0];
                default:           r_len  <= r_len;
            endcase
        end
    end

    assign norm_start = i_cfg_we && (i_cfg_index == pcb_pkg::REG_LEN);

    pcb_ptr_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_len   (len),
        .i_raw   (r_wp_raw[norm_sel]),
        .o_sel   (norm_sel),
        .o_busy  (norm_busy),
        .o_wr    (norm_wr)
    );

    // Transfer control: one stage for the memory read, one output register
    assign s1_mv      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !norm_busy && (!r_s1_valid || s1_mv);
    assign in_acc     = i_in_valid && o_in_ready;

    // Work out the channel update and the read address of this item
    always_comb begin
        ch       = i_channel[CH_W-1:0];
        ch_ok    = (int'(i_channel) < CHN);
        w        = r_wp_mod[ch];
        h        = (r_held[ch] < len) ? r_held[ch] : len;
        n        = ({1'b0, r_post} < (len - 1'b1)) ? r_post
                                                   : AW'(len - 1'b1);
        len_m_n  = len - {1'b0, n};
        wp_inc   = {1'b0, w} + 1'b1;
        wp_new   = (wp_inc == len) ? '0 : wp_inc[AW-1:0];
        h1       = (h < len) ? (h + 1'b1) : h;
        keep     = (h1 < len_m_n) ? h1 : len_m_n;
        do_write = ch_ok && (i_func == pcb_pkg::FUNC_WRITE)
                   && r_armed[ch] && !r_done[ch];

        // read address: oldest sample plus index, wrapped once
        rd_hit   = ch_ok && (i_func == pcb_pkg::FUNC_READ)
                   && ({1'b0, i_read_index} < h);
        rd_off   = (len - h) + {1'b0, i_read_index};
        rd_sum   = {1'b0, w} + rd_off;
        rd_phys  = (rd_sum >= len) ? (rd_sum - len) : rd_sum;

        upd      = 1'b0;
        n_wp     = r_wp_raw[ch];
        n_held   = r_held[ch];
        n_tpos   = r_tpos[ch];
        n_armed  = r_armed[ch];
        n_trig   = r_trig[ch];
        n_done   = r_done[ch];
        if (ch_ok && (i_func == pcb_pkg::FUNC_REARM)) begin
            upd     = 1'b1;
            n_wp    = '0;
            n_held  = '0;
            n_tpos  = '0;
            n_armed = 1'b1;
            n_trig  = 1'b0;
            n_done  = 1'b0;
        end else if (do_write) begin
            upd  = 1'b1;
            n_wp = wp_new;
            if (!r_trig[ch]) begin
                if (i_trigger) begin
                    n_held = keep;
                    n_tpos = AW'(keep - 1'b1);
                    n_trig = 1'b1;
                    n_done = (keep == len);
                end else begin
                    n_held = h1;
                end
            end else begin
                n_held = h1;
                n_done = (h1 >= len);
            end
        end
        n_fill = (n_held < len) ? n_held : len;
    end

    // Update channel state on transfer, pointer rewrap otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHN; i++) begin
                r_wp_raw[i] <= '0;
                r_wp_mod[i] <= '0;
                r_held[i]   <= '0;
                r_tpos[i]   <= '0;
            end
            r_armed <= '0;
            r_trig  <= '0;
            r_done  <= '0;
        end else begin
            if (in_acc && upd) begin
                r_wp_raw[ch] <= n_wp;
                r_wp_mod[ch] <= n_wp;
                r_held[ch]   <= n_held;
                r_tpos[ch]   <= n_tpos;
                r_armed[ch]  <= n_armed;
                r_trig[ch]   <= n_trig;
                r_done[ch]   <= n_done;
            end
            if (norm_wr.we) begin
                r_wp_mod[norm_wr.ch] <= norm_wr.ptr;
            end
        end
    end

    // Sample memory: one write and one registered read per cycle
    assign mem_we = in_acc && do_write;
    assign mem_wa = {ch, w};
    assign mem_re = in_acc && rd_hit;
    assign mem_ra = {ch, rd_phys[AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= i_sample[SW-1:0];
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_ra];
        end
    end

    // Stage 1: status of the item while the memory read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_mv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rd    <= rd_hit;
            r_s1_armed <= ch_ok && n_armed;
            r_s1_trig  <= ch_ok && n_trig;
            r_s1_done  <= ch_ok && n_done;
            r_s1_tidx  <= (ch_ok && n_trig) ? n_tpos : '0;
            r_s1_fill  <= ch_ok ? n_fill : '0;
        end
    end

    // Output register: load from stage 1, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_mv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_mv) begin
            r_out_data  <= r_s1_rd ? 32'(r_mem_q) : '0;
            r_out_armed <= r_s1_armed;
            r_out_trig  <= r_s1_trig;
            r_out_done  <= r_s1_done;
            r_out_tidx  <= r_s1_tidx;
            r_out_fill  <= r_s1_fill;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_data;
    assign o_armed         = r_out_armed;
    assign o_triggered     = r_out_trig;
    assign o_done_res      = r_out_done;
    assign o_trigger_index = r_out_tidx;
    assign o_fill_count    = r_out_fill;

    // Checks
    `PCB_ASSERT_IMP(a_no_xfer_in_rewrap, i_clk, i_rst_n, norm_busy, !o_in_ready)
    `PCB_ASSERT_NXT(a_len_write_rewraps, i_clk, i_rst_n, norm_start, norm_busy)
    `PCB_ASSERT_IMP(a_ptr_in_ring, i_clk, i_rst_n, in_acc && ch_ok, w < len)
    `PCB_ASSERT_IMP(a_read_in_ring, i_clk, i_rst_n, mem_re, rd_phys < len)
    `PCB_ASSERT_IMP(a_trig_needs_arm, i_clk, i_rst_n, in_acc && ch_ok && r_trig[ch],
                    r_armed[ch])

endmodule

FILE: design/pcb_ptr_norm.sv
// ----------------------------------------------------------------------------
// pcb_ptr_norm
// Recomputes every channel's write pointer modulo the record length after a
// length write: one restoring remainder step per cycle, AW steps per channel.
// ----------------------------------------------------------------------------
module pcb_ptr_norm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pcb_pkg::LEN_W-1:0]    i_len,
    input  logic [pcb_pkg::AW-1:0]       i_raw,
    output logic [pcb_pkg::CH_W-1:0]     o_sel,
    output logic                         o_busy,
    output pcb_pkg::t_ptr_wr             o_wr
);

    logic                         r_busy;
    logic [pcb_pkg::CH_W-1:0]     r_ch;
    logic [pcb_pkg::BIT_W-1:0]    r_bit;
    logic [pcb_pkg::AW-1:0]       r_rem;
    logic [pcb_pkg::LEN_W-1:0]    rem_sh;
    logic [pcb_pkg::LEN_W-1:0]    rem_nx;
    logic                         last_bit;
    logic                         last_ch;

    // Shift in the next pointer bit and subtract the length if it fits
    always_comb begin
        rem_sh   = {r_rem, i_raw[r_bit]};
        rem_nx   = (rem_sh >= i_len) ? (rem_sh - i_len) : rem_sh;
        last_bit = (r_bit == '0);
        last_ch  = (r_ch == pcb_pkg::CH_W'(pcb_pkg::CHANNELS - 1));
    end

    // Advance over bits, then channels; a new start restarts the sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ch   <= '0;
            r_bit  <= '0;
            r_rem  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_ch   <= '0;
            r_bit  <= pcb_pkg::BIT_W'(pcb_pkg::AW - 1);
            r_rem  <= '0;
        end else if (r_busy) begin
            if (last_bit) begin
                r_rem <= '0;
                r_bit <= pcb_pkg::BIT_W'(pcb_pkg::AW - 1);
                if (last_ch) begin
                    r_busy <= 1'b0;
                end else begin
                    r_ch <= r_ch + 1'b1;
                end
            end else begin
                r_rem <= rem_nx[pcb_pkg::AW-1:0];
                r_bit <= r_bit - 1'b1;
            end
        end
    end

    assign o_sel    = r_ch;
    assign o_busy   = r_busy;
    assign o_wr.we  = r_busy && last_bit && !i_start;
    assign o_wr.ch  = r_ch;
    assign o_wr.ptr = rem_nx[pcb_pkg::AW-1:0];

endmodule
